// ===== rtl/lgs_pkg.sv =====
// Shared types, constants and helper functions for the life generation stencil.
// Used by the column cell, the cell row and the top level; depends on nothing.
package lgs_pkg;

	// Default and fixed sizes.
	localparam int MAX_COLS_DEF = 32;
	localparam int MAX_ROWS     = 4096;
	localparam int ROWS_W       = 13;
	localparam int COLS_W       = 6;
	localparam int ROW_CNT_W    = 12;
	localparam int CFG_W        = 13;
	localparam int LIFE_BIRTH   = 3;

	// Configuration register indexes.
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// The two stored rows of one column.
	typedef struct packed {
		logic older;
		logic newer;
	} cell_pair_t;

	// Per-cell control from the row to one column cell.
	typedef struct packed {
		logic write;
		logic rotate;
		logic wrap;
	} cell_ctl_t;

	// Number of live cells in a 3x3 window.
	function automatic logic [3:0] count_ones9(input logic [8:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 9; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

	// Conway's rule on the 3x3 total that includes the center cell.
	function automatic logic life_rule(input logic [3:0] sum, input logic centre);
		return (sum == 4'(LIFE_BIRTH)) || (centre && (sum == 4'(LIFE_BIRTH + 1)));
	endfunction

endpackage

// ===== rtl/lgs_cell.sv =====
// One column cell: holds the two most recent rows of its column.
// Depends on lgs_pkg for the pair and control types.
module lgs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lgs_pkg::cell_ctl_t ctl,
	input  logic              din,
	input  lgs_pkg::cell_pair_t right,
	input  lgs_pkg::cell_pair_t head,
	output lgs_pkg::cell_pair_t q
);
	import lgs_pkg::*;

	cell_pair_t pair_q;

	// A write ages the column by one row; a rotate takes the right neighbor,
	// or the first cell when this is the last column of the grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (ctl.write) begin
			pair_q.older <= pair_q.newer;
			pair_q.newer <= din;
		end else if (ctl.rotate) begin
			pair_q <= ctl.wrap ? head : right;
		end
	end

	assign q = pair_q;

endmodule

// ===== rtl/lgs_cell_row.sv =====
// Row of column cells that forms both line stores of the stencil.
// Depends on lgs_pkg and lgs_cell.
module lgs_cell_row #(
	parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
	parameter int IW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	parameter int CNW      = $clog2(MAX_COLS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IW-1:0]      wr_col,
	input  logic               din,
	input  logic               rot_en,
	input  logic [CNW-1:0]     ceff,
	output lgs_pkg::cell_pair_t rd,
	output lgs_pkg::cell_pair_t head,
	output lgs_pkg::cell_pair_t second
);
	import lgs_pkg::*;

	cell_pair_t cells [MAX_COLS];
	logic [CNW-1:0] last_col;

	assign last_col = ceff - CNW'(1);

	// The chain: each cell hands its pair to its left neighbor on a rotate.
	for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
		cell_ctl_t  ctl;
		cell_pair_t right;

		assign ctl.write  = wr_en && (wr_col == IW'(j));
		assign ctl.rotate = rot_en && (CNW'(j) < ceff);
		assign ctl.wrap   = (CNW'(j) == last_col);

		if (j + 1 < MAX_COLS) begin : g_right
			assign right = cells[j+1];
		end else begin : g_end
			assign right = '0;
		end

		lgs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    (din),
			.right  (right),
			.head   (cells[0]),
			.q      (cells[j])
		);
	end

	// Read port at the current column, and the two head cells for the flush.
	assign rd   = cells[wr_col];
	assign head = cells[0];

	if (MAX_COLS > 1) begin : g_second
		assign second = cells[1];
	end else begin : g_no_second
		assign second = '0;
	end

endmodule

// ===== rtl/life_generation_stencil.sv =====
// Top level of the streaming Game of Life next-generation stencil.
// Depends on lgs_pkg and lgs_cell_row (which uses lgs_cell).
//
// The block takes one grid in raster order, one cell per item, and returns the
// next generation in raster order; cells outside the grid are dead. An item
// with at most one result leaves the block ready for the next item, so a row
// streams at one cell per cycle while the output does not stall. An item that
// carries both its own result and the row's right-edge result (the last column
// of any row but the first, in a grid wider than one column) holds the input
// while the edge result is sent, and the final cell of the grid holds it while
// the last row is flushed from the cell row, one result per cycle through the
// single output register while the output does not stall. The row and column
// counters restart for the next grid when the final cell is accepted. The line
// stores are a chain of one cell per column; the flush rotates the chain once
// around the grid width, so it leaves the stores as it found them.
module life_generation_stencil #(
	parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cell_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      cell_next,
	output logic                      grid_end
);
	import lgs_pkg::*;

	localparam int IW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam logic [COLS_W:0]   MAXC_EXT = (COLS_W + 1)'(MAX_COLS);
	localparam logic [ROWS_W-1:0] MAXR     = ROWS_W'(MAX_ROWS);

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_EDGE   = 2'd1;
	localparam logic [1:0] ST_FLUSH  = 2'd2;

	logic [ROWS_W-1:0]    grid_rows_q;
	logic [COLS_W-1:0]    grid_cols_q;
	logic [ROW_CNT_W-1:0] row_q;
	logic [IW-1:0]        col_q;
	logic [8:0]           window_q;
	logic [1:0]           state_q;
	logic [1:0]           state_d;
	logic                 edge_q;
	logic                 flush_pend_q;
	logic [IW-1:0]        k_q;
	cell_pair_t           prev_q;
	logic                 out_valid_q;
	logic                 cell_next_q;
	logic                 grid_end_q;

	logic [ROWS_W-1:0]    reff;
	logic [COLS_W:0]      cols_clamp;
	logic [CNW-1:0]       ceff;
	logic [ROW_CNT_W-1:0] r_sat;
	logic [IW-1:0]        c_sat;
	logic                 c_last;
	logic                 last;
	logic                 has_main;
	logic                 has_edge;
	logic                 out_free;
	logic                 in_acc;
	cell_pair_t           rd;
	cell_pair_t           head;
	cell_pair_t           second;
	cell_pair_t           rt;
	logic                 up1;
	logic                 up2;
	logic                 rows2;
	logic [8:0]           wnew;
	logic                 main_bit;
	logic                 edge_bit;
	logic                 k_last;
	logic [3:0]           fsum;
	logic                 flush_bit;
	logic                 load;
	logic                 load_cell;
	logic                 load_end;
	logic                 flush_step;

	// Effective grid size, with zero read as one and large values clamped.
	always_comb begin
		if (grid_rows_q == '0) begin
			reff = ROWS_W'(1);
		end else if (grid_rows_q > MAXR) begin
			reff = MAXR;
		end else begin
			reff = grid_rows_q;
		end
		if (grid_cols_q == '0) begin
			cols_clamp = (COLS_W + 1)'(1);
		end else if ({1'b0, grid_cols_q} > MAXC_EXT) begin
			cols_clamp = MAXC_EXT;
		end else begin
			cols_clamp = {1'b0, grid_cols_q};
		end
		ceff = CNW'(cols_clamp);
	end

	// Position of the current item, with counters saturated to the grid.
	assign r_sat  = ({1'b0, row_q} >= reff) ? ROW_CNT_W'(reff - ROWS_W'(1)) : row_q;
	assign c_sat  = (CNW'(col_q) >= ceff) ? IW'(ceff - CNW'(1)) : col_q;
	assign c_last = (CNW'(c_sat) == ceff - CNW'(1));
	assign last   = (r_sat == ROW_CNT_W'(reff - ROWS_W'(1))) && c_last;
	assign rows2  = (reff >= ROWS_W'(2));

	assign has_main = (r_sat != '0) && (c_sat != '0);
	assign has_edge = (r_sat != '0) && c_last;

	// Handshake: items enter only while no extra results are pending and the output register can take a result.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == ST_ACCEPT) && out_free);
	assign in_acc   = in_valid && !in_stall;

	lgs_cell_row #(
		.MAX_COLS (MAX_COLS),
		.IW       (IW),
		.CNW      (CNW)
	) u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_acc),
		.wr_col (c_sat),
		.din    (cell_in),
		.rot_en (flush_step),
		.ceff   (ceff),
		.rd     (rd),
		.head   (head),
		.second (second)
	);

	// New window column; rows above the grid read as dead.
	assign up2  = (r_sat > ROW_CNT_W'(1)) && rd.older;
	assign up1  = (r_sat != '0) && rd.newer;
	assign wnew = (c_sat == '0) ? {6'b0, up2, up1, cell_in}
	                            : {window_q[5:0], up2, up1, cell_in};

	assign main_bit = life_rule(count_ones9(wnew), wnew[4]);
	assign edge_bit = life_rule(count_ones9({3'b0, wnew[5:0]}), wnew[1]);

	// Flush result for column k of the last row, from the head of the chain.
	assign k_last    = (CNW'(k_q) == ceff - CNW'(1));
	assign rt        = k_last ? cell_pair_t'('0) : second;
	assign fsum      = count_ones9({3'b0,
		rows2 && prev_q.older, rows2 && head.older, rows2 && rt.older,
		prev_q.newer, head.newer, rt.newer});
	assign flush_bit = life_rule(fsum, head.newer);

	// Sequencer: accept items, then the pending edge result, then the flush.
	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		load_cell  = 1'b0;
		load_end   = 1'b0;
		flush_step = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				if (in_acc) begin
					load      = has_main || has_edge;
					load_cell = has_main ? main_bit : edge_bit;
					if (has_main && has_edge) begin
						state_d = ST_EDGE;
					end else if (last) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_EDGE: begin
				if (out_free) begin
					load      = 1'b1;
					load_cell = edge_q;
					state_d   = flush_pend_q ? ST_FLUSH : ST_ACCEPT;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					load       = 1'b1;
					load_cell  = flush_bit;
					load_end   = k_last;
					flush_step = 1'b1;
					if (k_last) begin
						state_d = ST_ACCEPT;
					end
				end
			end
			default: begin
				state_d = ST_ACCEPT;
			end
		endcase
	end

	// Configuration, counters, window, sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q  <= ROWS_W'(8);
			grid_cols_q  <= COLS_W'(8);
			row_q        <= '0;
			col_q        <= '0;
			window_q     <= '0;
			state_q      <= ST_ACCEPT;
			edge_q       <= 1'b0;
			flush_pend_q <= 1'b0;
			k_q          <= '0;
			prev_q       <= '0;
			out_valid_q  <= 1'b0;
			cell_next_q  <= 1'b0;
			grid_end_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_ROWS: grid_rows_q <= cfg_data[ROWS_W-1:0];
					REG_GRID_COLS: grid_cols_q <= cfg_data[COLS_W-1:0];
					default:       grid_rows_q <= grid_rows_q;
				endcase
			end

			if (in_acc) begin
				window_q     <= wnew;
				edge_q       <= edge_bit;
				flush_pend_q <= last;
				if (last) begin
					row_q <= '0;
					col_q <= '0;
				end else if (c_last) begin
					row_q <= r_sat + ROW_CNT_W'(1);
					col_q <= '0;
				end else begin
					row_q <= r_sat;
					col_q <= c_sat + IW'(1);
				end
			end

			state_q <= state_d;
			if ((state_d == ST_FLUSH) && (state_q != ST_FLUSH)) begin
				k_q    <= '0;
				prev_q <= '0;
			end else if (flush_step) begin
				k_q    <= k_q + IW'(1);
				prev_q <= head;
			end

			if (load) begin
				out_valid_q <= 1'b1;
				cell_next_q <= load_cell;
				grid_end_q  <= load_end;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign cell_next = cell_next_q;
	assign grid_end  = grid_end_q;

	// The last flush step leaves the block ready for a new grid at the origin.
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && out_free && k_last) |=>
		(state_q == ST_ACCEPT && row_q == '0 && col_q == '0 && out_valid_q && grid_end_q))
		else $error("flush did not end the grid cleanly");

	// An item with two results leaves the first in the output register.
	a_edge_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && has_main && has_edge) |=> (state_q == ST_EDGE && out_valid_q))
		else $error("edge result pending without a loaded output");

	// The flush column stays inside the grid.
	a_flush_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (CNW'(k_q) < ceff))
		else $error("flush column beyond grid width");

	// The end-of-grid mark is only produced by the flush.
	a_end_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(load && load_end) |-> (state_q == ST_FLUSH))
		else $error("grid end raised outside the flush");

endmodule

// ===== tb/life_generation_stencil_tb.sv =====
// Self-checking testbench for the streaming Game of Life stencil.
// Depends on lgs_pkg and life_generation_stencil; an internal model predicts
// each next-generation cell and an output monitor checks them in order.
`timescale 1ns / 1ps

module life_generation_stencil_tb;

	localparam int MAX_COLS = lgs_pkg::MAX_COLS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_ITEMS = 150;

	// One next-generation result cell.
	typedef struct packed {
		logic alive;
		logic grid_last;
	} life_res_t;

	typedef enum logic [1:0] {
		OP_CELL,
		OP_ROWS,
		OP_COLS
	} plan_op_e;

	// One row of the directed plan: a cell item or a register write.
	typedef struct packed {
		plan_op_e op;
		logic [lgs_pkg::CFG_W-1:0] arg;
		logic typed;
		life_res_t want;
	} plan_row_t;

	localparam life_res_t LONE_CELL_RES = '{alive: 1'b0, grid_last: 1'b1};
	localparam life_res_t NO_RES = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = lgs_pkg::REG_GRID_ROWS;
	logic [lgs_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic cell_in = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic cell_next;
	logic grid_end;

	// Model of the stencil: line stores, window, counters and sizes.
	bit older_row [MAX_COLS];
	bit newer_row [MAX_COLS];
	logic [8:0] window = '0;
	int unsigned row_cnt = 0;
	int unsigned col_cnt = 0;
	int unsigned size_rows = 8;
	int unsigned size_cols = 8;

	life_res_t step_out [$];
	life_res_t next_gen_q [$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	logic hold_req = 1'b0;

	life_generation_stencil dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cell_in  (cell_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_next(cell_next),
		.grid_end (grid_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Birth on exactly three live neighbors, survival on two or three.
	// The sum includes the center cell.
	function automatic logic survives(input int sum, input logic centre);
		return (sum == 3) || (centre && sum == 4);
	endfunction

	// Advance the model by one cell and collect the results it releases.
	function automatic void life_step(input logic b);
		int unsigned rows_eff, cols_eff, r, c, lo, hi, sum;
		logic up1, up2;
		step_out.delete();
		rows_eff = (size_rows == 0) ? 1 : (size_rows > lgs_pkg::MAX_ROWS) ?
			lgs_pkg::MAX_ROWS : size_rows;
		cols_eff = (size_cols == 0) ? 1 : (size_cols > MAX_COLS) ? MAX_COLS : size_cols;
		if (col_cnt >= cols_eff) col_cnt = cols_eff - 1;
		if (row_cnt >= rows_eff) row_cnt = rows_eff - 1;
		r = row_cnt;
		c = col_cnt;

		// Rows above the grid are dead, whatever the stores still hold.
		up2 = (r >= 2) ? older_row[c] : 1'b0;
		up1 = (r >= 1) ? newer_row[c] : 1'b0;
		older_row[c] = newer_row[c];
		newer_row[c] = b;
		if (c == 0)
			window = {6'b0, up2, up1, b};
		else
			window = {window[5:0], up2, up1, b};

		if (r >= 1 && c >= 1)
			step_out.push_back('{survives($countones(window), window[4]), 1'b0});
		// Right edge: the column beyond the grid is dead.
		if (r >= 1 && c == cols_eff - 1)
			step_out.push_back('{survives($countones(window[5:0]), window[1]), 1'b0});

		if (r == rows_eff - 1 && c == cols_eff - 1) begin
			// Last cell: the bottom row is flushed with dead cells below it.
			for (int j = 0; j < cols_eff; j++) begin
				sum = 0;
				lo = (j == 0) ? 0 : j - 1;
				hi = (j + 1 < cols_eff) ? j + 1 : j;
				for (int k = lo; k <= hi; k++) begin
					sum += newer_row[k];
					if (rows_eff >= 2) sum += older_row[k];
				end
				step_out.push_back('{survives(sum, newer_row[j]), j == cols_eff - 1});
			end
			row_cnt = 0;
			col_cnt = 0;
		end else begin
			col_cnt++;
			if (col_cnt >= cols_eff) begin
				col_cnt = 0;
				row_cnt++;
			end
		end
	endfunction

	// Offer one cell, in bursts with random gaps unless the phase is steady.
	task automatic send_cell(input logic b, input logic typed, input life_res_t want);
		if (!steady && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		cell_in <= b;
		do @(posedge clk); while (in_stall);
		life_step(b);
		if (typed)
			next_gen_q.push_back(want);
		else
			foreach (step_out[i]) next_gen_q.push_back(step_out[i]);
		if (burst_left > 0) burst_left--;
	endtask

	// Stop sending and wait until every predicted cell has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (next_gen_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// Register writes happen only with the block idle.
	task automatic write_reg(input logic idx, input logic [lgs_pkg::CFG_W-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lgs_pkg::REG_GRID_ROWS)
			size_rows = 32'(val);
		else
			size_cols = 32'(val[5:0]);
	endtask

	// Directed plan: reset sizes, a size change mid-grid, zero sizes,
	// a blinker, and oversized rows and columns cut down mid-grid.
	plan_row_t plan [28] = '{
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_ROWS, 13'd0, 1'b0, NO_RES},
		'{OP_COLS, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b1, LONE_CELL_RES},
		'{OP_CELL, 13'd0, 1'b1, LONE_CELL_RES},
		'{OP_ROWS, 13'd3, 1'b0, NO_RES},
		'{OP_COLS, 13'd3, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_ROWS, 13'd8191, 1'b0, NO_RES},
		'{OP_COLS, 13'd63, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd0, 1'b0, NO_RES},
		'{OP_ROWS, 13'd2, 1'b0, NO_RES},
		'{OP_COLS, 13'd2, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES},
		'{OP_CELL, 13'd1, 1'b0, NO_RES}
	};

	// Output monitor and receiver stall pattern, with one long hold-off.
	int hold_left = 0;
	bit hold_done = 1'b0;
	int pat_age = 0;
	logic [15:0] stall_pat = '0;
	life_res_t got, exp_res;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end

		if (out_valid && !out_stall) begin
			got = '{cell_next, grid_end};
			if (next_gen_q.size() == 0) begin
				if (errors < 20)
					$display("%t: expected no result, got cell_next=%b grid_end=%b",
						$time, cell_next, grid_end);
				errors++;
			end else begin
				exp_res = next_gen_q.pop_front();
				if (got.alive !== exp_res.alive) begin
					if (errors < 20)
						$display("%t: cell_next expected %b, got %b",
							$time, exp_res.alive, got.alive);
					errors++;
				end
				if (got.grid_last !== exp_res.grid_last) begin
					if (errors < 20)
						$display("%t: grid_end expected %b, got %b",
							$time, exp_res.grid_last, got.grid_last);
					errors++;
				end
			end
		end

		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			pat_age++;
			if (pat_age >= 48) begin
				pat_age = 0;
				case ($urandom_range(0, 3))
					0: stall_pat = '0;
					1: stall_pat = 16'($urandom);
					2: stall_pat = 16'($urandom & $urandom);
					default: stall_pat = 16'($urandom | $urandom);
				endcase
			end
			out_stall <= stall_pat[0];
			stall_pat = {stall_pat[0], stall_pat[15:1]};
		end
	end

	// Stimulus: reset, directed plan, then random phases of grids.
	initial begin
		int rand_items, phase_items, rows_eff, cols_eff, dens, grids;
		logic [12:0] rows_v;
		logic [5:0] cols_v;
		rand_items = 0;
		foreach (older_row[i]) begin
			older_row[i] = 1'b0;
			newer_row[i] = 1'b0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].op)
				OP_CELL: send_cell(plan[i].arg[0], plan[i].typed, plan[i].want);
				OP_ROWS: write_reg(lgs_pkg::REG_GRID_ROWS, plan[i].arg);
				default: write_reg(lgs_pkg::REG_GRID_COLS, plan[i].arg);
			endcase
		end

		// Full-width grid sent without gaps while the receiver holds off.
		write_reg(lgs_pkg::REG_GRID_ROWS, 13'd2);
		write_reg(lgs_pkg::REG_GRID_COLS, 13'd32);
		steady = 1'b1;
		hold_req <= 1'b1;
		for (int i = 0; i < 64; i++) begin
			send_cell(1'($urandom_range(0, 1)), 1'b0, NO_RES);
			rand_items++;
		end

		while (rand_items < RANDOM_ITEMS) begin
			grids = $urandom_range(1, 3);
			case ($urandom_range(0, 9))
				0: begin
					rows_v = 13'($urandom_range(0, 1));
					cols_v = 6'($urandom_range(0, 63));
				end
				1: begin
					rows_v = 13'($urandom_range(1, 2));
					cols_v = 6'($urandom_range(30, 63));
				end
				2: begin
					rows_v = 13'($urandom_range(4097, 8191));
					cols_v = 6'($urandom_range(1, 4));
				end
				default: begin
					rows_v = 13'($urandom_range(1, 5));
					cols_v = 6'($urandom_range(1, 6));
				end
			endcase
			write_reg(lgs_pkg::REG_GRID_ROWS, rows_v);
			write_reg(lgs_pkg::REG_GRID_COLS, {7'b0, cols_v});

			rows_eff = (rows_v == 0) ? 1 : (rows_v > lgs_pkg::MAX_ROWS) ?
				lgs_pkg::MAX_ROWS : rows_v;
			cols_eff = (cols_v == 0) ? 1 : (cols_v > MAX_COLS) ? MAX_COLS : cols_v;
			// Huge grids are only started; the next size change cuts them short.
			if (rows_eff > 8)
				phase_items = $urandom_range(1, 12);
			else begin
				phase_items = grids * rows_eff * cols_eff;
				if ($urandom_range(0, 5) == 0)
					phase_items = $urandom_range(1, phase_items);
			end
			// Keep the total item count near its target.
			if (phase_items > RANDOM_ITEMS - rand_items)
				phase_items = RANDOM_ITEMS - rand_items;

			steady = ($urandom_range(0, 3) == 0);
			dens = $urandom_range(0, 4);
			for (int i = 0; i < phase_items; i++) begin
				send_cell($urandom_range(0, 3) < dens, 1'b0, NO_RES);
				rand_items++;
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (next_gen_q.size() != 0) begin
			$display("%t: %0d expected results never arrived", $time, next_gen_q.size());
			errors++;
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
